/* src/cslex_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cslex_pkg
// Shared types, codes and character helpers of the C source lexer.
// ----------------------------------------------------------------------------
package cslex_pkg;

	// longest token length that is counted; longer tokens saturate
	localparam logic [7:0] LENGTH_LIMIT = 8'd255;

	// result queue between the lexer front and the output stage
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_LW    = $clog2(QUEUE_DEPTH + 1);

	// number of keywords
	localparam int KW_COUNT = 6;

	// keyword indexes
	localparam logic [2:0] KW_IF     = 3'd0;
	localparam logic [2:0] KW_ELSE   = 3'd1;
	localparam logic [2:0] KW_WHILE  = 3'd2;
	localparam logic [2:0] KW_INT    = 3'd3;
	localparam logic [2:0] KW_CHAR   = 3'd4;
	localparam logic [2:0] KW_RETURN = 3'd5;

	// token classes
	localparam logic [2:0] CLS_KEYWORD  = 3'd0;
	localparam logic [2:0] CLS_OPERATOR = 3'd1;
	localparam logic [2:0] CLS_NUMBER   = 3'd2;
	localparam logic [2:0] CLS_STRING   = 3'd3;
	localparam logic [2:0] CLS_IDENT    = 3'd4;

	// input word kinds
	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_END  = 1'b1;

	// characters with a meaning of their own
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_USCORE = 8'h5F;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;

	// lexer modes
	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_IDENT,
		MODE_NUMBER,
		MODE_STRING,
		MODE_SLASH,
		MODE_LINE,
		MODE_BLOCK
	} lex_mode_t;

	// input word
	typedef struct packed {
		logic       kind;
		logic [7:0] byte_req;
	} lex_in_t;

	// result word
	typedef struct packed {
		logic [2:0]  token_class;
		logic [2:0]  keyword_index;
		logic [15:0] start_line;
		logic [15:0] start_column;
		logic [31:0] start_offset;
		logic [7:0]  token_length;
		logic [7:0]  first_byte;
		logic        length_saturated;
		logic        unterminated;
		logic        last;
	} lex_out_t;

	// writes from the lexer front into the queue
	typedef struct packed {
		logic valid_a;
		logic valid_b;
	} lex_push_t;

	// queue status towards the front and the output stage
	typedef struct packed {
		logic                room;
		logic [QUEUE_LW-1:0] level;
	} lex_qstat_t;

	// single-character operators
	function automatic logic is_op(input logic [7:0] c);
		logic r;
		case (c) inside
			"+", "-", "*", "/", "<", ">", "=", "!", "&", "|",
			"(", ")", ",", ";", "{", "}", "[", "]": r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		logic [7:0] l;
		l = c | 8'h20;
		return (l >= "a") && (l <= "z");
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	// keyword length
	function automatic logic [2:0] kw_len(input logic [2:0] k);
		logic [2:0] r;
		unique case (k)
			KW_IF:     r = 3'd2;
			KW_ELSE:   r = 3'd4;
			KW_WHILE:  r = 3'd5;
			KW_INT:    r = 3'd3;
			KW_CHAR:   r = 3'd4;
			KW_RETURN: r = 3'd6;
			default:   r = 3'd0;
		endcase
		return r;
	endfunction

	// keyword character at a position, left-aligned text
	function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] i);
		logic [47:0] t;
		logic [47:0] s;
		unique case (k)
			KW_IF:     t = {"if", 32'd0};
			KW_ELSE:   t = {"else", 16'd0};
			KW_WHILE:  t = {"while", 8'd0};
			KW_INT:    t = {"int", 24'd0};
			KW_CHAR:   t = {"char", 16'd0};
			KW_RETURN: t = "return";
			default:   t = 48'd0;
		endcase
		s = t << {i, 3'b000};
		return s[47:40];
	endfunction

	// keywords that still agree with character c at position pos
	function automatic logic [KW_COUNT-1:0] kw_match(input logic [7:0] c,
		input logic [7:0] pos);
		logic [KW_COUNT-1:0] r;
		for (int k = 0; k < KW_COUNT; k++) begin
			r[k] = (pos < {5'd0, kw_len(3'(k))}) && (kw_char(3'(k), pos[2:0]) == c);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

/* src/cslex_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cslex_front
// Lexer front: takes one input word, tracks mode and position, and
// produces up to two result words for the queue.
// ----------------------------------------------------------------------------
module cslex_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               accept,
	input  wire cslex_pkg::lex_in_t src,
	output cslex_pkg::lex_push_t    push,
	output cslex_pkg::lex_out_t     word_a,
	output cslex_pkg::lex_out_t     word_b
);
	import cslex_pkg::*;

	lex_mode_t           mode_q, mode_d, start_mode;
	logic [15:0]         line_q, col_q, tok_line_q, tok_col_q;
	logic [31:0]         off_q, tok_off_q;
	logic [7:0]          tok_cnt_q, tok_first_q;
	logic                tok_over_q, star_q;
	logic [KW_COUNT-1:0] kw_q, kw_d;

	logic [7:0]  c;
	logic        is_end;
	logic        c_alpha, c_digit, c_ident, c_numch, c_op;
	logic [15:0] col_next;
	logic [7:0]  cnt_inc;
	logic        over_inc;
	logic        restart, flush_a, emit_b, grow_en, open_en, star_d;
	logic        kw_hit;
	logic [2:0]  kw_idx;

	// character classes of the incoming byte
	assign c        = src.byte_req;
	assign is_end   = (src.kind == KIND_END);
	assign c_alpha  = is_alpha(c);
	assign c_digit  = is_digit(c);
	assign c_ident  = c_alpha || c_digit || (c == CH_USCORE);
	assign c_numch  = c_digit || (c == CH_DOT);
	assign c_op     = is_op(c);
	assign col_next = (col_q != 16'hFFFF) ? col_q + 16'd1 : col_q;
	assign cnt_inc  = (tok_cnt_q < LENGTH_LIMIT) ? tok_cnt_q + 8'd1 : tok_cnt_q;
	assign over_inc = tok_over_q || (tok_cnt_q >= LENGTH_LIMIT);

	// mode entered by a byte that begins a new token
	always_comb begin
		if (c == CH_HASH)
			start_mode = MODE_LINE;
		else if (c == CH_QUOTE)
			start_mode = MODE_STRING;
		else if (c_alpha || c == CH_USCORE)
			start_mode = MODE_IDENT;
		else if (c_digit)
			start_mode = MODE_NUMBER;
		else if (c == CH_SLASH)
			start_mode = MODE_SLASH;
		else
			start_mode = MODE_IDLE;
	end

	// next mode
	always_comb begin
		mode_d = mode_q;
		if (is_end) begin
			mode_d = MODE_IDLE;
		end else begin
			unique case (mode_q)
				MODE_IDENT:  if (!c_ident) mode_d = start_mode;
				MODE_NUMBER: if (!c_numch) mode_d = start_mode;
				MODE_STRING: if (c == CH_QUOTE) mode_d = MODE_IDLE;
				MODE_SLASH: begin
					if (c == CH_SLASH)
						mode_d = MODE_LINE;
					else if (c == CH_STAR)
						mode_d = MODE_BLOCK;
					else
						mode_d = start_mode;
				end
				MODE_LINE:   if (c == CH_NL) mode_d = MODE_IDLE;
				MODE_BLOCK:  if (star_q && c == CH_SLASH) mode_d = MODE_IDLE;
				MODE_IDLE:   mode_d = start_mode;
				default:     mode_d = start_mode;
			endcase
		end
	end

	// per-mode actions: flush, restart, grow, star tracking
	always_comb begin
		restart = 1'b0;
		flush_a = 1'b0;
		grow_en = 1'b0;
		star_d  = star_q;
		if (is_end) begin
			flush_a = (mode_q == MODE_IDENT) || (mode_q == MODE_NUMBER) ||
			          (mode_q == MODE_STRING) || (mode_q == MODE_SLASH);
		end else begin
			unique case (mode_q)
				MODE_IDENT: begin
					grow_en = c_ident;
					flush_a = !c_ident;
					restart = !c_ident;
				end
				MODE_NUMBER: begin
					grow_en = c_numch;
					flush_a = !c_numch;
					restart = !c_numch;
				end
				MODE_STRING: begin
					grow_en = 1'b1;
					flush_a = (c == CH_QUOTE);
				end
				MODE_SLASH: begin
					if (c == CH_STAR) begin
						star_d = 1'b0;
					end else if (c != CH_SLASH) begin
						flush_a = 1'b1;
						restart = 1'b1;
					end
				end
				MODE_LINE: ;
				MODE_BLOCK: star_d = (c == CH_STAR);
				MODE_IDLE: restart = 1'b1;
				default:   restart = 1'b1;
			endcase
		end
	end

	assign emit_b  = restart && c_op && (c != CH_SLASH);
	assign open_en = restart && (c_op || c_ident || c == CH_QUOTE) && !c_digit
	                 ? 1'b1 : (restart && c_digit);

	// keyword tracking while a name is read
	always_comb begin
		kw_d = kw_q;
		if (!is_end && mode_q == MODE_IDENT && c_ident)
			kw_d = kw_q & kw_match(c, tok_cnt_q);
		else if (restart && (c_alpha || c == CH_USCORE))
			kw_d = kw_match(c, 8'd0);
	end

	// keyword decision for a finished name, lowest index wins
	always_comb begin
		kw_hit = 1'b0;
		kw_idx = KW_IF;
		for (int k = KW_COUNT - 1; k >= 0; k--) begin
			if (kw_q[k] && tok_cnt_q == {5'd0, kw_len(3'(k))} && !tok_over_q) begin
				kw_hit = 1'b1;
				kw_idx = 3'(k);
			end
		end
	end

	// pending token word
	always_comb begin
		word_a.keyword_index    = KW_IF;
		word_a.start_line       = tok_line_q;
		word_a.start_column     = tok_col_q;
		word_a.start_offset     = tok_off_q;
		word_a.token_length     = tok_cnt_q;
		word_a.first_byte       = tok_first_q;
		word_a.length_saturated = tok_over_q;
		word_a.unterminated     = 1'b0;
		word_a.last             = !emit_b;
		unique case (mode_q)
			MODE_IDENT: begin
				word_a.token_class   = kw_hit ? CLS_KEYWORD : CLS_IDENT;
				word_a.keyword_index = kw_hit ? kw_idx : KW_IF;
			end
			MODE_NUMBER: word_a.token_class = CLS_NUMBER;
			MODE_STRING: begin
				word_a.token_class = CLS_STRING;
				if (is_end)
					word_a.unterminated = 1'b1;
				else begin
					word_a.token_length     = cnt_inc;
					word_a.length_saturated = over_inc;
				end
			end
			default: word_a.token_class = CLS_OPERATOR;
		endcase
	end

	// operator word started by this byte
	always_comb begin
		word_b.token_class      = CLS_OPERATOR;
		word_b.keyword_index    = KW_IF;
		word_b.start_line       = line_q;
		word_b.start_column     = col_next;
		word_b.start_offset     = off_q;
		word_b.token_length     = 8'd1;
		word_b.first_byte       = c;
		word_b.length_saturated = 1'b0;
		word_b.unterminated     = 1'b0;
		word_b.last             = 1'b1;
	end

	assign push.valid_a = accept && flush_a;
	assign push.valid_b = accept && !is_end && emit_b;

	// lexer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_IDLE;
			line_q      <= 16'd1;
			col_q       <= 16'd0;
			off_q       <= 32'd0;
			tok_line_q  <= 16'd1;
			tok_col_q   <= 16'd0;
			tok_off_q   <= 32'd0;
			tok_cnt_q   <= 8'd0;
			tok_first_q <= 8'd0;
			tok_over_q  <= 1'b0;
			kw_q        <= '1;
			star_q      <= 1'b0;
		end else if (accept) begin
			if (is_end) begin
				mode_q      <= MODE_IDLE;
				line_q      <= 16'd1;
				col_q       <= 16'd0;
				off_q       <= 32'd0;
				tok_line_q  <= 16'd1;
				tok_col_q   <= 16'd0;
				tok_off_q   <= 32'd0;
				tok_cnt_q   <= 8'd0;
				tok_first_q <= 8'd0;
				tok_over_q  <= 1'b0;
				kw_q        <= '1;
				star_q      <= 1'b0;
			end else begin
				mode_q <= mode_d;
				kw_q   <= kw_d;
				star_q <= star_d;
				off_q  <= off_q + 32'd1;
				if (c == CH_NL) begin
					if (line_q != 16'hFFFF)
						line_q <= line_q + 16'd1;
					col_q <= 16'd0;
				end else begin
					col_q <= col_next;
				end
				if (open_en) begin
					tok_line_q  <= line_q;
					tok_col_q   <= col_next;
					tok_off_q   <= off_q;
					tok_cnt_q   <= 8'd1;
					tok_first_q <= c;
					tok_over_q  <= 1'b0;
				end else if (grow_en) begin
					tok_cnt_q  <= cnt_inc;
					tok_over_q <= over_inc;
				end
			end
		end
	end

endmodule
`default_nettype wire

/* src/cslex_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cslex_queue
// Short result queue: takes up to two words a cycle from the front,
// hands one a cycle to the output stage when it asks for one.
// ----------------------------------------------------------------------------
module cslex_queue (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire cslex_pkg::lex_push_t push,
	input  wire cslex_pkg::lex_out_t  word_a,
	input  wire cslex_pkg::lex_out_t  word_b,
	input  wire logic                 pop,
	output cslex_pkg::lex_out_t       head,
	output cslex_pkg::lex_qstat_t     stat
);
	import cslex_pkg::*;

	lex_out_t            mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q, wr_b;
	logic [QUEUE_LW-1:0] level_q;
	logic [QUEUE_LW-1:0] n_push;

	assign wr_b   = wr_ptr_q + QUEUE_AW'(push.valid_a);
	assign n_push = QUEUE_LW'(push.valid_a) + QUEUE_LW'(push.valid_b);

	// room for two words is needed before a new input word is taken
	assign stat.room  = (level_q <= QUEUE_LW'(QUEUE_DEPTH - 2));
	assign stat.level = level_q;
	assign head       = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push.valid_a)
			mem_q[wr_ptr_q] <= word_a;
		if (push.valid_b)
			mem_q[wr_b] <= word_b;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QUEUE_AW'(n_push);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			level_q <= level_q + n_push - QUEUE_LW'(pop);
		end
	end

endmodule
`default_nettype wire

/* src/cslex_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cslex_back
// Output stage: registers the queue head onto the result channel and
// holds it while the receiver stalls.
// ----------------------------------------------------------------------------
module cslex_back (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cslex_pkg::lex_out_t   head,
	input  wire cslex_pkg::lex_qstat_t stat,
	output logic                       pop,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output cslex_pkg::lex_out_t        out_word
);
	import cslex_pkg::*;

	logic     valid_q;
	lex_out_t word_q;

	// load when the register is empty or its word is being taken
	assign pop       = (stat.level != '0) && (!valid_q || !out_stall);
	assign out_valid = valid_q;
	assign out_word  = word_q;

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (pop)
			valid_q <= 1'b1;
		else if (!out_stall)
			valid_q <= 1'b0;
	end

	// output word
	always_ff @(posedge clk) begin
		if (pop)
			word_q <= head;
	end

endmodule
`default_nettype wire

/* src/c_source_lexer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// c_source_lexer
// C source lexer: one source byte per word in, one token per word out.
// ----------------------------------------------------------------------------
// Input channel src_*: a word is a source byte (kind 0) or an end-of-text
// mark (kind 1) that flushes a pending token and returns line, column and
// offset to the start of a new text.
// Output channel tok_*: one word per token with class, keyword index, start
// position, length and first byte; last marks the final word of an input.
// A byte gives no, one or two tokens (a name, number or slash ended by an
// operator).
// Path: the byte ending a token writes it into the queue at the edge that
// accepts the byte; the output register then loads it from the queue and
// raises tok_valid, once the register is empty or its word is being taken.
// Throughput: one byte per cycle; the lexer front updates mode, position and
// keyword match in a single step. The output side carries one token per
// cycle, so src_stall rises while the four-entry queue holds more than two
// tokens, which only a run of two-token bytes or a stalled receiver causes.
// Reset: all lexer state returns to line 1, column 0, offset 0, no pending
// token, empty queue and no output word.
// Receiver stall: the output word holds, the queue fills and the source is
// stalled in turn; no word is lost.
// ----------------------------------------------------------------------------
module c_source_lexer (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                src_valid,
	output logic                     src_stall,
	input  wire cslex_pkg::lex_in_t  src_word,
	output logic                     tok_valid,
	input  wire logic                tok_stall,
	output cslex_pkg::lex_out_t      tok_word
);
	import cslex_pkg::*;

	lex_push_t  push;
	lex_out_t   word_a, word_b, head;
	lex_qstat_t stat;
	logic       accept, pop;

	assign src_stall = !stat.room;
	assign accept    = src_valid && !src_stall;

	// lexer front
	cslex_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.src    (src_word),
		.push   (push),
		.word_a (word_a),
		.word_b (word_b)
	);

	// result queue
	cslex_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.word_a (word_a),
		.word_b (word_b),
		.pop    (pop),
		.head   (head),
		.stat   (stat)
	);

	// output register
	cslex_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.stat      (stat),
		.pop       (pop),
		.out_valid (tok_valid),
		.out_stall (tok_stall),
		.out_word  (tok_word)
	);

`ifndef SYNTH
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stat.level <= QUEUE_LW'(QUEUE_DEPTH))
		else $error("result queue over its depth");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(stat.level == '0) |-> !pop)
		else $error("output stage loaded from an empty queue");

	a_push_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(push.valid_a || push.valid_b) |-> accept)
		else $error("token written without an accepted input word");

	a_pair_last: assert property (@(posedge clk) disable iff (!arst_n)
		(push.valid_a && push.valid_b) |-> (!word_a.last && word_b.last))
		else $error("wrong last flag on a two-token byte");
`endif

endmodule
`default_nettype wire

/* sim/c_source_lexer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_source_lexer_tb
// Feeds the lexer with C-like text and checks every token word it returns.
// ----------------------------------------------------------------------------
// A queue of source words is built at time zero. It starts with a short
// directed part, then well-formed fragments with random content mixed with
// noise. A clocked driver offers the words in random bursts. A clocked
// monitor keeps its own tokenizer state, works out the tokens of every
// accepted word and compares each returned token with the oldest one still
// due. The receiver stalls on its own pattern and twice holds off for a long
// stretch. The sender once waits until every due token has arrived.
// ----------------------------------------------------------------------------
module c_source_lexer_tb;
	import cslex_pkg::*;

	// operator characters and characters used inside block comments
	localparam logic [8*18-1:0] OPERATOR_CHARS = "+-*/<>=!&|(),;{}[]";
	localparam logic [8*5-1:0]  COMMENT_CHARS  = "*/a \n";
	localparam logic [2:0]      NO_KEYWORD     = 3'd0;
	localparam logic [15:0]     COUNT_TOP      = 16'hFFFF;

	// stimulus sizes and pressure points
	localparam int RANDOM_WORDS = 1650;
	localparam int DRAIN_POINT  = 700;
	localparam int LONG_HOLD    = 300;

	logic     clk;
	logic     arst_n    = 1'b0;
	logic     src_valid = 1'b0;
	logic     src_stall;
	lex_in_t  src_word  = '0;
	logic     tok_valid;
	logic     tok_stall = 1'b0;
	lex_out_t tok_word;

	c_source_lexer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_word  (src_word),
		.tok_valid (tok_valid),
		.tok_stall (tok_stall),
		.tok_word  (tok_word)
	);

	// source words still to send and tokens still to arrive
	lex_in_t  source_text [$];
	lex_out_t due_tokens [$];
	lex_out_t want_token;

	int failures      = 0;
	int words_seen    = 0;
	int ends_seen     = 0;
	int tokens_seen   = 0;
	int keyword_hits  = 0;
	int string_hits   = 0;
	int open_strings  = 0;
	int capped_tokens = 0;

	// tokenizer state of the monitor
	lex_mode_t   lex_state;
	logic [15:0] line_no;
	logic [15:0] col_no;
	logic [31:0] offset_no;
	logic [15:0] tok_line;
	logic [15:0] tok_col;
	logic [31:0] tok_off;
	logic [7:0]  tok_len;
	logic [7:0]  tok_first;
	logic [5:0]  kw_live;
	logic        star_prev;
	logic        tok_over;
	int          step_tokens;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// character classes and keyword spelling
	// ------------------------------------------------------------------
	function automatic bit letter(logic [7:0] c);
		logic [7:0] l;
		l = c | 8'h20;
		return (l >= "a") && (l <= "z");
	endfunction

	function automatic bit numeral(logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic bit op_char(logic [7:0] c);
		for (int i = 0; i < 18; i++)
			if (OPERATOR_CHARS[8*i +: 8] == c) return 1'b1;
		return 1'b0;
	endfunction

	function automatic string keyword_spelling(int k);
		case (3'(k))
			KW_IF:     return "if";
			KW_ELSE:   return "else";
			KW_WHILE:  return "while";
			KW_INT:    return "int";
			KW_CHAR:   return "char";
			KW_RETURN: return "return";
			default:   return "";
		endcase
	endfunction

	// ------------------------------------------------------------------
	// tokenizer
	// ------------------------------------------------------------------
	function automatic void clear_lexer();
		lex_state = MODE_IDLE;
		line_no   = 16'd1;
		col_no    = 16'd0;
		offset_no = 32'd0;
		tok_line  = 16'd1;
		tok_col   = 16'd0;
		tok_off   = 32'd0;
		tok_len   = 8'd0;
		tok_first = 8'd0;
		kw_live   = '1;
		star_prev = 1'b0;
		tok_over  = 1'b0;
	endfunction

	function automatic void emit_token(logic [2:0] cls, logic [2:0] kwi, logic unterm);
		lex_out_t t;
		t.token_class      = cls;
		t.keyword_index    = kwi;
		t.start_line       = tok_line;
		t.start_column     = tok_col;
		t.start_offset     = tok_off;
		t.token_length     = tok_len;
		t.first_byte       = tok_first;
		t.length_saturated = tok_over;
		t.unterminated     = unterm;
		t.last             = 1'b0;
		due_tokens.push_back(t);
		step_tokens++;
	endfunction

	// a finished name is a keyword only if a spelling survived at full length
	function automatic void emit_name();
		string s;
		for (int k = 0; k < KW_COUNT; k++) begin
			s = keyword_spelling(k);
			if (kw_live[k] && tok_len == s.len() && !tok_over) begin
				emit_token(CLS_KEYWORD, 3'(k), 1'b0);
				return;
			end
		end
		emit_token(CLS_IDENT, NO_KEYWORD, 1'b0);
	endfunction

	function automatic void narrow_keywords(logic [7:0] c, logic [7:0] pos);
		string s;
		for (int k = 0; k < KW_COUNT; k++) begin
			s = keyword_spelling(k);
			if (pos >= s.len() || s[pos] != c) kw_live[k] = 1'b0;
		end
	endfunction

	function automatic void hold_token(logic [7:0] c, logic [15:0] ln, logic [15:0] col,
		logic [31:0] off);
		tok_line  = ln;
		tok_col   = col;
		tok_off   = off;
		tok_len   = 8'd1;
		tok_first = c;
		tok_over  = 1'b0;
	endfunction

	function automatic void grow_token();
		if (tok_len < LENGTH_LIMIT) tok_len++;
		else tok_over = 1'b1;
	endfunction

	// a byte seen outside any token or comment
	function automatic void open_item(logic [7:0] c, logic [15:0] ln, logic [15:0] col,
		logic [31:0] off);
		lex_state = MODE_IDLE;
		if (c == CH_HASH) begin
			lex_state = MODE_LINE;
		end else if (c == CH_QUOTE) begin
			hold_token(c, ln, col, off);
			lex_state = MODE_STRING;
		end else if (letter(c) || c == CH_USCORE) begin
			hold_token(c, ln, col, off);
			kw_live = '1;
			narrow_keywords(c, 8'd0);
			lex_state = MODE_IDENT;
		end else if (numeral(c)) begin
			hold_token(c, ln, col, off);
			lex_state = MODE_NUMBER;
		end else if (c == CH_SLASH) begin
			hold_token(c, ln, col, off);
			lex_state = MODE_SLASH;
		end else if (op_char(c)) begin
			hold_token(c, ln, col, off);
			emit_token(CLS_OPERATOR, NO_KEYWORD, 1'b0);
		end
	endfunction

	// tokens caused by one accepted word go onto the due queue
	function automatic void tokenize_word(lex_in_t w);
		logic [7:0]  c;
		logic [15:0] ln;
		logic [15:0] col;
		logic [31:0] off;
		lex_out_t    t;
		step_tokens = 0;
		c = w.byte_req;
		if (w.kind == KIND_END) begin
			case (lex_state)
				MODE_IDENT:  emit_name();
				MODE_NUMBER: emit_token(CLS_NUMBER, NO_KEYWORD, 1'b0);
				MODE_STRING: emit_token(CLS_STRING, NO_KEYWORD, 1'b1);
				MODE_SLASH:  emit_token(CLS_OPERATOR, NO_KEYWORD, 1'b0);
				default: ;
			endcase
			clear_lexer();
		end else begin
			ln  = line_no;
			col = (col_no != COUNT_TOP) ? col_no + 16'd1 : COUNT_TOP;
			off = offset_no;
			case (lex_state)
				MODE_IDENT: begin
					if (letter(c) || numeral(c) || c == CH_USCORE) begin
						narrow_keywords(c, tok_len);
						grow_token();
					end else begin
						emit_name();
						open_item(c, ln, col, off);
					end
				end
				MODE_NUMBER: begin
					if (numeral(c) || c == CH_DOT) begin
						grow_token();
					end else begin
						emit_token(CLS_NUMBER, NO_KEYWORD, 1'b0);
						open_item(c, ln, col, off);
					end
				end
				MODE_STRING: begin
					grow_token();
					if (c == CH_QUOTE) begin
						emit_token(CLS_STRING, NO_KEYWORD, 1'b0);
						lex_state = MODE_IDLE;
					end
				end
				MODE_SLASH: begin
					if (c == CH_SLASH) begin
						lex_state = MODE_LINE;
					end else if (c == CH_STAR) begin
						lex_state = MODE_BLOCK;
						star_prev = 1'b0;
					end else begin
						emit_token(CLS_OPERATOR, NO_KEYWORD, 1'b0);
						open_item(c, ln, col, off);
					end
				end
				MODE_LINE: begin
					if (c == CH_NL) lex_state = MODE_IDLE;
				end
				MODE_BLOCK: begin
					if (star_prev && c == CH_SLASH) lex_state = MODE_IDLE;
					star_prev = (c == CH_STAR);
				end
				default: open_item(c, ln, col, off);
			endcase
			offset_no = off + 32'd1;
			if (c == CH_NL) begin
				if (line_no != COUNT_TOP) line_no++;
				col_no = 16'd0;
			end else begin
				col_no = col;
			end
		end
		// mark the final token of this word
		if (step_tokens > 0) begin
			t = due_tokens.pop_back();
			t.last = 1'b1;
			due_tokens.push_back(t);
		end
	endfunction

	// ------------------------------------------------------------------
	// stimulus building
	// ------------------------------------------------------------------
	function automatic void put_byte(logic [7:0] c);
		lex_in_t w;
		w.kind     = KIND_BYTE;
		w.byte_req = c;
		source_text.push_back(w);
	endfunction

	function automatic void put_end();
		lex_in_t w;
		w.kind     = KIND_END;
		w.byte_req = 8'($urandom_range(0, 255));
		source_text.push_back(w);
	endfunction

	function automatic void put_text(string s);
		for (int i = 0; i < s.len(); i++) put_byte(s[i]);
	endfunction

	// name character; the first one is never a digit
	function automatic logic [7:0] name_byte(bit first);
		int r;
		r = first ? $urandom_range(0, 52) : $urandom_range(0, 62);
		if (r < 26) return "a" + 8'(r);
		if (r < 52) return "A" + 8'(r - 26);
		if (r == 52) return CH_USCORE;
		return "0" + 8'(r - 53);
	endfunction

	// mostly short tokens, now and then a long one near or past the length limit
	function automatic int token_size();
		if ($urandom_range(0, 39) == 0) return $urandom_range(250, 300);
		return $urandom_range(1, 12);
	endfunction

	function automatic logic [7:0] plain_byte();
		logic [7:0] c;
		c = 8'($urandom_range(0, 255));
		return (c == CH_NL) ? " " : c;
	endfunction

	task automatic add_fragment();
		int         n;
		int         i;
		string      s;
		logic [7:0] c;
		case ($urandom_range(0, 19))
			0, 1, 2, 3: begin
				s = keyword_spelling($urandom_range(0, KW_COUNT - 1));
				case ($urandom_range(0, 3))
					0: put_text(s.substr(0, s.len() - 2));
					1: begin
						put_text(s);
						put_byte(name_byte(1'b0));
					end
					default: put_text(s);
				endcase
			end
			4, 5: begin
				n = token_size();
				put_byte(name_byte(1'b1));
				repeat (n - 1) put_byte(name_byte(1'b0));
			end
			6, 7: begin
				n = token_size();
				put_byte("0" + 8'($urandom_range(0, 9)));
				repeat (n - 1)
					put_byte(($urandom_range(0, 4) == 0) ? CH_DOT : "0" + 8'($urandom_range(0, 9)));
			end
			8, 9: begin
				i = $urandom_range(0, 17);
				put_byte(OPERATOR_CHARS[8*i +: 8]);
			end
			10: begin
				n = token_size();
				put_byte(CH_QUOTE);
				repeat (n) begin
					c = 8'($urandom_range(0, 255));
					put_byte((c == CH_QUOTE) ? CH_NL : c);
				end
				if ($urandom_range(0, 7) != 0) put_byte(CH_QUOTE);
			end
			11: begin
				put_text("//");
				repeat ($urandom_range(0, 10)) put_byte(plain_byte());
				put_byte(CH_NL);
			end
			12: begin
				put_byte(CH_HASH);
				repeat ($urandom_range(0, 10)) put_byte(plain_byte());
				put_byte(CH_NL);
			end
			13: begin
				put_text("/*");
				repeat ($urandom_range(0, 10)) begin
					i = $urandom_range(0, 4);
					put_byte(COMMENT_CHARS[8*i +: 8]);
				end
				put_text("*/");
			end
			14: put_byte(8'($urandom_range(0, 255)));
			15: begin
				put_byte(CH_SLASH);
				put_byte(8'($urandom_range(0, 255)));
			end
			16, 17, 18: put_byte(($urandom_range(0, 1) == 0) ? " " : CH_NL);
			default: begin
				if ($urandom_range(0, 2) == 0) put_end();
				else put_byte("\t");
			end
		endcase
		// separator, or none so that tokens run into each other
		case ($urandom_range(0, 3))
			1: put_byte(" ");
			2: put_byte(CH_NL);
			3: put_byte("\t");
			default: ;
		endcase
	endtask

	// ------------------------------------------------------------------
	// sender: bursts of random length with random gaps
	// ------------------------------------------------------------------
	int burst_left;
	int gap_left;
	int words_sent;
	bit drain_done;

	always @(posedge clk) begin
		if (!arst_n) begin
			src_valid  <= 1'b0;
			src_word   <= '0;
			burst_left = 0;
			gap_left   = 0;
			words_sent = 0;
			drain_done = 1'b0;
		end else begin
			if (src_valid && !src_stall) words_sent++;
			if (!src_valid || !src_stall) begin
				if (words_sent == DRAIN_POINT && !drain_done) begin
					// pause until every due token has come back
					src_valid <= 1'b0;
					if (!src_valid && due_tokens.size() == 0) drain_done = 1'b1;
				end else if (gap_left > 0) begin
					gap_left--;
					src_valid <= 1'b0;
				end else if (source_text.size() > 0) begin
					src_valid <= 1'b1;
					src_word  <= source_text.pop_front();
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 40);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end
				end else begin
					src_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// receiver stall pattern with two long hold-offs
	// ------------------------------------------------------------------
	int unsigned rx_cycle;
	int          hold_left;

	always @(posedge clk) begin
		if (!arst_n) begin
			tok_stall <= 1'b0;
			rx_cycle  = 0;
			hold_left = 0;
		end else begin
			rx_cycle++;
			if (rx_cycle == 400 || rx_cycle == 1100) hold_left = LONG_HOLD;
			if (hold_left > 0) begin
				hold_left--;
				tok_stall <= 1'b1;
			end else begin
				case (rx_cycle[9:8])
					2'd0: tok_stall <= 1'b0;
					2'd1: tok_stall <= ($urandom_range(0, 3) == 0);
					2'd2: tok_stall <= ($urandom_range(0, 3) != 0);
					default: tok_stall <= (rx_cycle[2:0] < 3'd3);
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// monitor: check returned tokens, then tokenize the accepted word
	// ------------------------------------------------------------------
	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			failures++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (tok_valid && !tok_stall) begin
				tokens_seen++;
				if (due_tokens.size() == 0) begin
					$error("token word with none due: class %0d offset %0d",
						tok_word.token_class, tok_word.start_offset);
					failures++;
				end else begin
					want_token = due_tokens.pop_front();
					check_field("token_class", 32'(want_token.token_class),
						32'(tok_word.token_class));
					check_field("keyword_index", 32'(want_token.keyword_index),
						32'(tok_word.keyword_index));
					check_field("start_line", 32'(want_token.start_line),
						32'(tok_word.start_line));
					check_field("start_column", 32'(want_token.start_column),
						32'(tok_word.start_column));
					check_field("start_offset", want_token.start_offset, tok_word.start_offset);
					check_field("token_length", 32'(want_token.token_length),
						32'(tok_word.token_length));
					check_field("first_byte", 32'(want_token.first_byte),
						32'(tok_word.first_byte));
					check_field("length_saturated", 32'(want_token.length_saturated),
						32'(tok_word.length_saturated));
					check_field("unterminated", 32'(want_token.unterminated),
						32'(tok_word.unterminated));
					check_field("last", 32'(want_token.last), 32'(tok_word.last));
					if (want_token.token_class == CLS_KEYWORD) keyword_hits++;
					if (want_token.token_class == CLS_STRING) string_hits++;
					if (want_token.unterminated) open_strings++;
					if (want_token.length_saturated) capped_tokens++;
				end
			end
			if (src_valid && !src_stall) begin
				if (src_word.kind == KIND_END) ends_seen++;
				else words_seen++;
				tokenize_word(src_word);
			end
		end
	end

	// ------------------------------------------------------------------
	// stimulus, reset and end of run
	// ------------------------------------------------------------------
	initial begin
		int base_words;
		clear_lexer();

		// keyword then operator, number cut by slash, slash as operator,
		// slash-star-slash inside a comment, unterminated string with odd bytes
		put_text("if(9./x/*/*/\"");
		put_byte(8'hFF);
		put_byte(8'h00);
		put_end();
		// directive line, then a lone slash flushed by end of text
		put_text("#a\n/");
		put_end();
		put_text("_1");
		put_end();

		// random part
		base_words = source_text.size();
		while (source_text.size() - base_words < RANDOM_WORDS)
			add_fragment();
		put_end();

		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// all words sent, then all tokens back, then a short tail
		@(posedge clk);
		while (source_text.size() != 0 || src_valid) @(posedge clk);
		@(posedge clk);
		while (due_tokens.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		@(negedge clk);
		if (due_tokens.size() != 0) begin
			$error("%0d tokens never returned", due_tokens.size());
			failures++;
		end

		$display("covered %0d source bytes and %0d end-of-text marks, %0d tokens returned",
			words_seen, ends_seen, tokens_seen);
		$display("%0d keywords, %0d strings (%0d unterminated), %0d length-capped tokens",
			keyword_hits, string_hits, open_strings, capped_tokens);
		if (failures == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// watchdog
	initial begin
		#60_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule

/* filelist.f */
src/cslex_pkg.sv
src/cslex_front.sv
src/cslex_queue.sv
src/cslex_back.sv
src/c_source_lexer.sv
sim/c_source_lexer_tb.sv
